@@ hw/rtl/lru_block_cache_tags_assert.svh @@
// Assertion macros shared by the checker of the LRU block cache tag store.
`ifndef LRU_BLOCK_CACHE_TAGS_ASSERT_SVH
`define LRU_BLOCK_CACHE_TAGS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LBCT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LBCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/lbct_pkg.sv @@
// Shared types, codes and microcode program of the LRU block cache tag store.
`default_nettype none

package lbct_pkg;

    localparam int CACHE_ENTRIES_DEF = 8;
    localparam int BLOCK_W = 32;
    localparam int STAMP_W = 32;
    localparam int WAY_W   = 3;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL       = 2'd1;
    localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BLOCK_W-1:0] block_number;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } rsp_t;

    typedef logic [3:0] step_t;

    // The miss step directly follows the branch step, so a lookup that found
    // nothing falls through to it.
    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_LK_START  = 4'd1;
    localparam step_t STEP_LK_SCAN   = 4'd2;
    localparam step_t STEP_LK_BRANCH = 4'd3;
    localparam step_t STEP_LK_MISS   = 4'd4;
    localparam step_t STEP_LK_HIT    = 4'd5;
    localparam step_t STEP_FL_START  = 4'd6;
    localparam step_t STEP_FL_SCAN   = 4'd7;
    localparam step_t STEP_FL_WRITE  = 4'd8;
    localparam step_t STEP_INVAL     = 4'd9;
    localparam step_t STEP_NOP       = 4'd10;
    localparam step_t STEP_EMIT      = 4'd11;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_REQ,
        COND_SCAN_DONE,
        COND_FOUND,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_next;
        logic eval_lookup;
        logic eval_min;
        logic wr_hit;
        logic wr_fill;
        logic clr_all;
        logic res_zero;
        logic emit;
    } dp_ctl_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic out_free;
    } dp_sts_t;

    typedef struct packed {
        dp_ctl_t ctl;
        cond_t   cond;
        logic    loop;
        logic    dispatch;
        step_t   target;
    } ucode_t;

    // Control store: taken jump goes to target (or the op entry point),
    // otherwise hold on a looping step or fall through to the next one.
    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        w        = '0;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
        case (step)
            STEP_IDLE:
            begin
                w.ctl.accept = 1'b1;
                w.cond       = COND_REQ;
                w.dispatch   = 1'b1;
                w.loop       = 1'b1;
            end
            STEP_LK_START:
            begin
                w.ctl.scan_start = 1'b1;
                w.target         = STEP_LK_SCAN;
            end
            STEP_LK_SCAN:
            begin
                w.ctl.scan_next   = 1'b1;
                w.ctl.eval_lookup = 1'b1;
                w.cond            = COND_SCAN_DONE;
                w.target          = STEP_LK_BRANCH;
                w.loop            = 1'b1;
            end
            STEP_LK_BRANCH:
            begin
                w.cond   = COND_FOUND;
                w.target = STEP_LK_HIT;
            end
            STEP_LK_HIT:
            begin
                w.ctl.wr_hit = 1'b1;
                w.target     = STEP_EMIT;
            end
            STEP_LK_MISS:
            begin
                w.ctl.res_zero = 1'b1;
                w.target       = STEP_EMIT;
            end
            STEP_FL_START:
            begin
                w.ctl.scan_start = 1'b1;
                w.target         = STEP_FL_SCAN;
            end
            STEP_FL_SCAN:
            begin
                w.ctl.scan_next = 1'b1;
                w.ctl.eval_min  = 1'b1;
                w.cond          = COND_SCAN_DONE;
                w.target        = STEP_FL_WRITE;
                w.loop          = 1'b1;
            end
            STEP_FL_WRITE:
            begin
                w.ctl.wr_fill = 1'b1;
                w.target      = STEP_EMIT;
            end
            STEP_INVAL:
            begin
                w.ctl.clr_all  = 1'b1;
                w.ctl.res_zero = 1'b1;
                w.target       = STEP_EMIT;
            end
            STEP_NOP:
            begin
                w.ctl.res_zero = 1'b1;
                w.target       = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                w.ctl.emit = 1'b1;
                w.cond     = COND_OUT_FREE;
                w.target   = STEP_IDLE;
                w.loop     = 1'b1;
            end
            default:
            begin
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic step_t dispatch_step(logic [OP_W-1:0] op);
        step_t s;
        case (op)
            OP_LOOKUP:     s = STEP_LK_START;
            OP_FILL:       s = STEP_FL_START;
            OP_INVALIDATE: s = STEP_INVAL;
            default:       s = STEP_NOP;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lru_block_cache_tags.sv @@
// Top level of the LRU block cache tag store: sequencer plus datapath.
`default_nettype none

// Tag and replacement store of a fully associative block cache with
// timestamp LRU. Each request item carries an op (lookup, fill after a
// miss, invalidate all) and a block number; each produces exactly one
// response item with hit and way. A lookup reports the lowest matching
// non-empty entry and restamps it; a fill replaces the entry with the
// smallest stamp (lowest index on ties, empty entries first) and reports
// its way; invalidate empties all entries and restarts the use counter at
// one. Way is the entry index modulo 8. The block handles one item at a
// time: a small microcoded sequencer walks the entry memory through its
// single read port, one entry per cycle; a lookup stops at the first
// hit, a fill scans every entry, and invalidate or an unused op does not
// scan. The response sits in an output register, so the next request is
// accepted while an earlier response still waits on rsp_ready. Entries
// are cleared by per-entry valid bits, so no clearing pass follows reset.
module lru_block_cache_tags
    import lbct_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    dp_ctl_t ctl;
    dp_sts_t sts;

    // Step counter and control store; accepts items only in its idle step.
    lbct_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.op),
        .sts       (sts),
        .ctl       (ctl),
        .req_ready (req_ready)
    );

    // Entry memory, scan compare, stamp counter and response register.
    lbct_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req_valid (req_valid),
        .req_block (req.block_number),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ hw/rtl/lbct_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none

module lbct_seq
    import lbct_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic [OP_W-1:0] req_op,
    input  dp_sts_t         sts,
    output dp_ctl_t         ctl,
    output logic            req_ready
);

    step_t  pc_reg;
    step_t  pc_next;
    ucode_t word;
    logic   take;

    assign word      = ucode_rom(pc_reg);
    assign ctl       = word.ctl;
    assign req_ready = word.ctl.accept;

    always_comb
    begin
        case (word.cond)
            COND_ALWAYS:    take = 1'b1;
            COND_REQ:       take = req_valid;
            COND_SCAN_DONE: take = sts.scan_done;
            COND_FOUND:     take = sts.found;
            COND_OUT_FREE:  take = sts.out_free;
            default:        take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            pc_next = word.dispatch ? dispatch_step(req_op) : word.target;
        end
        else if (word.loop)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lbct_dp.sv @@
// Datapath: entry memory, valid bits, scan pointer, compare and result register.
`default_nettype none

module lbct_dp
    import lbct_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_ctl_t            ctl,
    input  logic               req_valid,
    input  logic [BLOCK_W-1:0] req_block,
    input  logic               rsp_ready,
    output dp_sts_t            sts,
    output logic               rsp_valid,
    output rsp_t               rsp
);

    localparam int AW      = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int IW      = AW + 1;
    localparam int ENTRY_W = BLOCK_W + STAMP_W;

    // Each word holds {block, stamp}.
    logic [ENTRY_W-1:0]       entry_mem [CACHE_ENTRIES];

    logic [BLOCK_W-1:0]       blk_reg;
    logic [IW-1:0]            scan_idx_reg;
    logic [IW-1:0]            scan_idx_next;
    logic [AW-1:0]            rd_idx_reg;
    logic [ENTRY_W-1:0]       rd_data_reg;
    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic                     found_reg;
    logic [AW-1:0]            hit_idx_reg;
    logic [AW-1:0]            best_idx_reg;
    logic [STAMP_W-1:0]       best_stamp_reg;
    logic [STAMP_W-1:0]       counter_reg;
    rsp_t                     res_reg;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_reg;

    logic [AW-1:0]            rd_addr;
    logic [STAMP_W-1:0]       rd_stamp;
    logic [BLOCK_W-1:0]       rd_block;
    logic                     match;
    logic                     last;
    logic                     better;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic                     out_free;
    logic                     out_load;

    function automatic logic [WAY_W-1:0] to_way(logic [AW-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[WAY_W-1:0];
    endfunction

    assign rd_addr  = ctl.scan_start ? '0 : scan_idx_reg[AW-1:0];
    // An entry never written since the last clear reads as empty.
    assign rd_stamp = valid_reg[rd_idx_reg] ? rd_data_reg[STAMP_W-1:0] : '0;
    assign rd_block = rd_data_reg[ENTRY_W-1:STAMP_W];
    assign match    = (rd_stamp != '0) && (rd_block == blk_reg);
    assign last     = (rd_idx_reg == AW'(CACHE_ENTRIES - 1));
    assign better   = (rd_idx_reg == '0) || (rd_stamp < best_stamp_reg);

    assign wr_en    = ctl.wr_hit | ctl.wr_fill;
    assign wr_addr  = ctl.wr_hit ? hit_idx_reg : best_idx_reg;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign out_load = ctl.emit && out_free;

    assign sts.scan_done = last || (ctl.eval_lookup && match);
    assign sts.found     = found_reg;
    assign sts.out_free  = out_free;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (ctl.scan_start)
        begin
            scan_idx_next = IW'(1);
        end
        else if (ctl.scan_next)
        begin
            scan_idx_next = scan_idx_reg + IW'(1);
        end
        else
        begin
            scan_idx_next = scan_idx_reg;
        end
    end

    assign rsp_valid_next = out_load || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= {blk_reg, counter_reg};
        end
        rd_data_reg <= entry_mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept && req_valid)
        begin
            blk_reg <= req_block;
        end
        if (ctl.eval_lookup && match && !found_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (ctl.eval_min && better)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_stamp_reg <= rd_stamp;
        end
        if (ctl.wr_hit)
        begin
            res_reg <= '{hit: 1'b1, way: to_way(hit_idx_reg)};
        end
        else if (ctl.wr_fill)
        begin
            res_reg <= '{hit: 1'b0, way: to_way(best_idx_reg)};
        end
        else if (ctl.res_zero)
        begin
            res_reg <= '0;
        end
        if (out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            valid_reg     <= '0;
            found_reg     <= 1'b0;
            counter_reg   <= STAMP_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            scan_idx_reg  <= scan_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ctl.scan_start)
            begin
                found_reg <= 1'b0;
            end
            else if (ctl.eval_lookup && match)
            begin
                found_reg <= 1'b1;
            end
            if (ctl.clr_all)
            begin
                valid_reg   <= '0;
                counter_reg <= STAMP_W'(1);
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
                counter_reg        <= counter_reg + STAMP_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lbct_checker.sv @@
// Port-level checker for the LRU block cache tag store, bound to the top level.
`default_nettype none

`include "lru_block_cache_tags_assert.svh"

module lbct_checker
    import lbct_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // Hold a stalled response.
    `LBCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response dropped or changed while stalled")
    // Take one item at a time.
    `LBCT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while another is in work")
    // No response can appear the cycle right after an accept.
    `LBCT_ASSERT_NEXT(a_no_early_rsp, req_valid && req_ready, !$rose(rsp_valid), "response appeared too early")
    // Raise a response only out of the emit step, never with req_ready high right after an accept.
    `LBCT_ASSERT_IMPL(a_no_rsp_in_idle_start, $rose(rsp_valid), !req_ready || !$past(req_valid && req_ready), "response raised in the accept cycle")

endmodule

bind lru_block_cache_tags lbct_checker u_lbct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

@@ tb/lbct_checker.sv @@
// Scoreboard for the LRU block cache tag store: tracks tag state, predicts and compares.
module lbct_scoreboard
    import lbct_pkg::*;
#(
    parameter int ENTRIES = CACHE_ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatches,
    output int   awaiting,
    output int   requests,
    output int   lookup_hits,
    output int   fills
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [BLOCK_W-1:0] tag_block [ENTRIES];
    logic [STAMP_W-1:0] tag_stamp [ENTRIES];
    logic [STAMP_W-1:0] next_stamp;
    rsp_t               due_hit_way [$];

    task automatic empty_tags();
        for (int k = 0; k < ENTRIES; k++)
        begin
            tag_block[k] = '0;
            tag_stamp[k] = '0;
        end
        next_stamp = 1;
    endtask

    // Apply one request to the tag copy and return the response it must produce.
    task automatic lru_access(input req_t r, output rsp_t res);
        int  victim;
        bit  found;
        res    = '0;
        found  = 1'b0;
        victim = 0;
        case (r.op)
            OP_LOOKUP:
            begin
                for (int k = 0; k < ENTRIES; k++)
                begin
                    if (!found && tag_stamp[k] != '0 && tag_block[k] == r.block_number)
                    begin
                        tag_stamp[k] = next_stamp;
                        next_stamp   = next_stamp + 1;
                        res.hit      = 1'b1;
                        res.way      = WAY_W'(k);
                        found        = 1'b1;
                    end
                end
            end
            OP_FILL:
            begin
                for (int k = 1; k < ENTRIES; k++)
                begin
                    if (tag_stamp[victim] > tag_stamp[k])
                        victim = k;
                end
                tag_block[victim] = r.block_number;
                tag_stamp[victim] = next_stamp;
                next_stamp        = next_stamp + 1;
                res.way           = WAY_W'(victim);
            end
            OP_INVALIDATE:
                empty_tags();
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t pred;
        if (!rst_n)
        begin
            empty_tags();
            due_hit_way.delete();
            mismatches  = 0;
            awaiting    = 0;
            requests    = 0;
            lookup_hits = 0;
            fills       = 0;
        end
        else
        begin
            // Retire the response first; it always belongs to an earlier request.
            if (rsp_valid && rsp_ready)
            begin
                if (due_hit_way.size() == 0)
                begin
                    $error("response with nothing outstanding: hit %0b way %0d",
                           rsp.hit, rsp.way);
                    mismatches++;
                end
                else
                begin
                    want = due_hit_way.pop_front();
                    if (rsp.hit !== want.hit)
                    begin
                        $error("hit: expected %0b, got %0b", want.hit, rsp.hit);
                        mismatches++;
                    end
                    if (rsp.way !== want.way)
                    begin
                        $error("way: expected %0d, got %0d", want.way, rsp.way);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                lru_access(req, pred);
                due_hit_way.push_back(pred);
                requests++;
                if (pred.hit)
                    lookup_hits++;
                if (req.op == OP_FILL)
                    fills++;
            end
            awaiting = due_hit_way.size();
        end
    end

endmodule

@@ tb/tb_lru_block_cache_tags.sv @@
// Top of the LRU block cache tag store testbench: clock, reset, stimulus and verdict.
module tb_lru_block_cache_tags
    import lbct_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Op code the block must treat as a no-op.
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int RANDOM_ITEMS = 500;
    localparam int POOL_SIZE    = 12;
    localparam int LONG_HOLD    = 300;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int mismatches;
    int awaiting;
    int requests;
    int lookup_hits;
    int fills;

    // Shared pacing knobs: calm turns off idling on both sides, hold_request
    // makes the receiver sit out one long stretch.
    bit calm;
    bit hold_request;
    bit long_hold_done;

    logic [BLOCK_W-1:0] block_pool [POOL_SIZE];

    lru_block_cache_tags DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lbct_scoreboard u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .awaiting    (awaiting),
        .requests    (requests),
        .lookup_hits (lookup_hits),
        .fills       (fills)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #2ms;
        $display("timeout: %0d responses still outstanding", awaiting);
        $display("tb_lru_block_cache_tags NOT OK");
        $finish;
    end

    // Offer one request item: idle for a random gap (none when calm), then
    // hold valid and payload until the block takes it. Valid is lowered
    // only when a gap follows, so back-to-back items keep it high.
    task automatic offer(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] blk);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.op           <= op;
        req.block_number <= blk;
        req_valid        <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Receiver: draw a stall per item, then take the next response.
    initial
    begin
        int stall;
        rsp_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_request)
            begin
                stall          = LONG_HOLD;
                hold_request   = 1'b0;
                long_hold_done = 1'b1;
            end
            else
                stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int sent;
        int pick;
        int slot;
        logic [BLOCK_W-1:0] blk;

        req_valid    <= 1'b0;
        req          <= '0;
        rst_n        <= 1'b0;
        calm         = 1'b0;
        hold_request = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Lookup of block zero on an empty store must miss: empty entries read
        // as unstamped, whatever block they hold.
        offer(OP_LOOKUP, 32'h0000_0000);
        offer(OP_RESERVED, 32'hFFFF_FFFF);
        offer(OP_FILL, 32'h0000_0000);
        offer(OP_LOOKUP, 32'h0000_0000);
        offer(OP_FILL, 32'hFFFF_FFFF);
        // Fill the remaining empty entries in index order.
        offer(OP_FILL, 32'h8000_0000);
        offer(OP_FILL, 32'h5555_5555);
        offer(OP_FILL, 32'hAAAA_AAAA);
        offer(OP_FILL, 32'h0000_0001);
        offer(OP_FILL, 32'h7FFF_FFFF);
        offer(OP_FILL, 32'h0000_0003);
        offer(OP_LOOKUP, 32'hFFFF_FFFF);
        // Store is full: these evict the least recently stamped entries.
        offer(OP_FILL, 32'h0000_0007);
        offer(OP_FILL, 32'h0000_0008);
        // Same block installed twice; lookup must report the lower index.
        offer(OP_FILL, 32'hFFFF_FFFF);
        offer(OP_LOOKUP, 32'hFFFF_FFFF);
        offer(OP_LOOKUP, 32'h1234_5678);
        offer(OP_LOOKUP, 32'h5555_5555);
        offer(OP_RESERVED, 32'h0000_0000);
        offer(OP_LOOKUP, 32'h5555_5555);
        offer(OP_INVALIDATE, 32'hFFFF_FFFF);
        offer(OP_LOOKUP, 32'hFFFF_FFFF);
        offer(OP_LOOKUP, 32'h5555_5555);
        offer(OP_FILL, 32'h0000_0005);
        offer(OP_INVALIDATE, 32'h0000_0000);

        // Random part. Draw blocks mostly from a small pool, a bit larger than
        // the store, so hits, misses and evictions all occur.
        for (int i = 0; i < POOL_SIZE; i++)
            block_pool[i] = $urandom();
        block_pool[0] = 32'h0000_0000;
        block_pool[1] = 32'hFFFF_FFFF;

        // Let the receiver stall long while requests keep coming, so the
        // output register fills and the block backs up its input.
        hold_request = 1'b1;

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // Switch between idling and full-rate stretches now and then.
            if (sent % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            // Refresh one pool slot occasionally so new blocks keep arriving.
            if ($urandom_range(0, 19) == 0)
            begin
                slot             = $urandom_range(2, POOL_SIZE - 1);
                block_pool[slot] = $urandom();
            end
            blk  = block_pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // Usual access pattern: look up, then install after a miss.
                offer(OP_LOOKUP, blk);
                sent++;
                if ($urandom_range(0, 1) == 1)
                begin
                    offer(OP_FILL, blk);
                    sent++;
                end
            end
            else if (pick < 78)
            begin
                offer(OP_LOOKUP, blk);
                sent++;
            end
            else if (pick < 88)
            begin
                offer(OP_FILL, blk);
                sent++;
            end
            else if (pick < 95)
            begin
                offer(($urandom_range(0, 1) == 1) ? OP_FILL : OP_LOOKUP, $urandom());
                sent++;
            end
            else if (pick < 98)
            begin
                offer(OP_INVALIDATE, $urandom());
                sent++;
            end
            else
            begin
                offer(OP_RESERVED, $urandom());
                sent++;
            end
        end
        req_valid <= 1'b0;

        // Drain: wait for every response, then keep clocking to catch strays.
        while (awaiting != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("run covered %0d requests: %0d lookup hits, %0d fills", requests,
                 lookup_hits, fills);
        $display("long receiver hold applied: %0d, mismatches: %0d", long_hold_done,
                 mismatches);
        if (mismatches == 0 && awaiting == 0)
            $display("tb_lru_block_cache_tags OK");
        else
            $display("tb_lru_block_cache_tags NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lbct_pkg.sv
hw/rtl/lbct_seq.sv
hw/rtl/lbct_dp.sv
hw/rtl/lru_block_cache_tags.sv
hw/rtl/lbct_checker.sv
tb/lbct_checker.sv
tb/tb_lru_block_cache_tags.sv
